>>> rtl/mefc_pkg.sv
// Shared types, constants and codes of the multichannel edge frequency counter.
`default_nettype none
package mefc_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CH_OK_W      = 7;
    localparam int REC_W        = 96;
    localparam int DIV_STEPS    = 32;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [26:0] SCALE_CENTIHZ = 27'd100000000;

    typedef enum logic [1:0] {
        CMD_EDGE    = 2'd0,
        CMD_TIMEOUT = 2'd1,
        CMD_READ    = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  channel;
        logic        level;
        logic [31:0] tick;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  read_channel;
        logic [31:0] edge_tally;
        logic [30:0] span_ticks;
        logic [31:0] freq_centihertz;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [30:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_LOAD,
        S_MUL,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> rtl/mefc_if.sv
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none
interface mefc_in_if;
    import mefc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mefc_out_if;
    import mefc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/mefc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mefc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/mefc_div.sv
// Shift-subtract divider: 64-bit numerator over 31-bit divisor, saturating 32-bit quotient.
`default_nettype none
module mefc_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mefc_pkg::t_div_req i_req,
    output mefc_pkg::t_div_rsp      o_rsp
);
    import mefc_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]          r_rem, n_rem;
    logic [31:0]          r_quo, n_quo;
    logic [30:0]          r_den, n_den;
    logic [32:0]          w_trial;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quo[31]};
    assign w_fit   = w_trial >= {2'b00, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_den = i_req.den;
            // A high half at or above the divisor means the quotient needs more than 32 bits.
            if (i_req.num[63:32] >= {1'b0, i_req.den}) begin
                n_quo  = '1;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_rem  = i_req.num[63:32];
                n_quo  = i_req.num[31:0];
                n_cnt  = '0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            // The low word shifts out numerator bits and shifts in quotient bits.
            n_rem = w_fit ? 32'(w_trial - {2'b00, r_den}) : w_trial[31:0];
            n_quo = {r_quo[30:0], w_fit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule
`default_nettype wire

>>> rtl/multichannel_edge_frequency_counter_top.sv
// Multichannel reciprocal frequency counter: per-channel record store and read sequencer.
//
// The input channel carries edge events, timeout events and read requests, one beat
// per command. Each channel keeps its first and last edge tick and a rising-edge count
// in a RAM; written and pending-clear flags live in flip-flops that reset clears at once,
// so a record never written reads as zero and no clearing pass is needed.
// An edge or timeout beat passes through accept, RAM read and update before the block is ready again.
// A read beat passes through accept, RAM read, one multiply
// of the tally by the centihertz scale, then 32 steps of the shared shift-subtract
// divider; the next beat can be accepted as soon as its result is valid. A read with zero tally or
// zero span skips the divider; a saturating
// quotient ends the divider at once.
// The result sits in an output register; the next input beat is accepted while it
// waits. A second read that finishes while the receiver still stalls holds until the
// output register is free. Reset is synchronous and empties every channel record,
// clears the result register and leaves the block ready for input.
`default_nettype none
module multichannel_edge_frequency_counter_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mefc_in_if.sink    i_in,
    mefc_out_if.source o_out
);
    import mefc_pkg::*;

    t_state            r_state, n_state;
    logic [1:0]        r_cmd;
    logic [4:0]        r_chan;
    logic              r_level;
    logic [31:0]       r_tick;
    logic [NUM_CHANNELS-1:0] r_written;
    logic [NUM_CHANNELS-1:0] r_pend;
    logic [31:0]       r_tally;
    logic [30:0]       r_span;
    logic [63:0]       r_num;
    logic [31:0]       r_freq;
    t_out_item         r_out;
    logic              r_out_valid;

    logic [CH_AW-1:0]  w_addr;
    logic              w_chan_ok;
    logic              w_vis;
    logic [REC_W-1:0]  w_rdata;
    logic [REC_W-1:0]  w_wdata;
    logic [31:0]       w_first, w_last, w_count;
    logic [31:0]       w_first_new, w_count_new;
    logic [31:0]       w_diff;
    logic [30:0]       w_span;
    logic [58:0]       w_prod;
    logic              w_zero;
    logic              w_out_free;
    logic              w_re, w_we, w_ready;
    logic              w_div_start;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign w_addr     = CH_AW'(r_chan);
    assign w_chan_ok  = {2'b00, r_chan} < CH_OK_W'(NUM_CHANNELS);
    assign w_out_free = !r_out_valid || o_out.ready;

    // A read sees the stored record even if a clear is pending; an edge sees it cleared.
    assign w_vis   = r_written[w_addr] && (r_cmd == CMD_READ || !r_pend[w_addr]);
    assign w_first = w_vis ? w_rdata[95:64] : '0;
    assign w_last  = w_vis ? w_rdata[63:32] : '0;
    assign w_count = w_vis ? w_rdata[31:0]  : '0;

    assign w_first_new = (w_first == '0) ? r_tick : w_first;
    assign w_count_new = w_count + {31'b0, r_level};
    assign w_wdata     = {w_first_new, r_tick, w_count_new};

    always_comb begin
        w_diff = w_last - w_first;
        if (w_diff == '0) begin
            w_diff = 32'd1;
        end
        w_span = w_diff[31] ? '0 : w_diff[30:0];
    end

    assign w_prod = 59'(r_tally) * 59'(SCALE_CENTIHZ);
    assign w_zero = (r_tally == '0) || (r_span == '0);

    mefc_ram #(
        .WIDTH  (REC_W),
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (CH_AW)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_div_req.start = w_div_start;
    assign w_div_req.num   = r_num;
    assign w_div_req.den   = r_span;

    mefc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_FETCH;
            S_FETCH: n_state = S_LOAD;
            S_LOAD:  n_state = (r_cmd == CMD_READ) ? S_MUL : S_IDLE;
            S_MUL:   n_state = w_zero ? S_DONE : S_START;
            S_START: n_state = S_DIV;
            S_DIV:   if (w_div_rsp.done) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_ready     = 1'b0;
        w_re        = 1'b0;
        w_we        = 1'b0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE:  w_ready = 1'b1;
            S_FETCH: w_re = 1'b1;
            S_LOAD:  w_we = (r_cmd == CMD_EDGE) && w_chan_ok;
            S_START: w_div_start = 1'b1;
            default: ;
        endcase
    end

    assign i_in.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_written   <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOAD && w_chan_ok) begin
                unique case (r_cmd)
                    CMD_EDGE: begin
                        r_written[w_addr] <= 1'b1;
                        r_pend[w_addr]    <= 1'b0;
                    end
                    CMD_TIMEOUT: begin
                        if (r_pend[w_addr]) begin
                            r_written[w_addr] <= 1'b0;
                            r_pend[w_addr]    <= 1'b0;
                        end
                    end
                    CMD_READ: r_pend[w_addr] <= 1'b1;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (r_state == S_IDLE && i_in.valid) begin
            r_cmd   <= i_in.data.command;
            r_chan  <= i_in.data.channel;
            r_level <= i_in.data.level;
            r_tick  <= i_in.data.tick;
        end
        if (r_state == S_LOAD) begin
            r_tally <= w_chan_ok ? w_count : '0;
            r_span  <= w_chan_ok ? w_span  : '0;
        end
        if (r_state == S_MUL) begin
            // Adding half the span rounds the quotient to nearest.
            r_num  <= 64'(w_prod) + 64'(r_span[30:1]);
            r_freq <= '0;
        end
        if (r_state == S_DIV && w_div_rsp.done) begin
            r_freq <= w_div_rsp.quot;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out.read_channel    <= r_chan;
            r_out.edge_tally      <= r_tally;
            r_out.span_ticks      <= r_span;
            r_out.freq_centihertz <= r_freq;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire

>>> rtl/mefc_checker.sv
// Port-level checks of the frequency counter top level, bound to every instance.
`default_nettype none
module mefc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire mefc_pkg::t_out_item i_out_data
);
    import mefc_pkg::*;

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result beat changed or dropped");

    // One beat at a time: an accepted beat always makes the block busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready stayed high after an accepted beat");

    // A new result is loaded only from the final sequencer step, never from idle.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared while the block was idle");

    a_zero_freq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.span_ticks == '0 || i_out_data.edge_tally == '0)
        |-> i_out_data.freq_centihertz == '0)
        else $error("nonzero frequency with zero tally or zero span");

endmodule

bind multichannel_edge_frequency_counter_top mefc_checker u_mefc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire

>>> bench/multichannel_edge_frequency_counter_top_test.sv
// Self-checking bench for the multichannel edge frequency counter: edge trains, reads and noise.
`default_nettype none
module multichannel_edge_frequency_counter_top_test;
    import mefc_pkg::*;

    localparam int         TARGET_BEATS = 650;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 64;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    // Per-channel record keeper and result checker.
    class freq_ledger;
        logic [31:0] start_stamp [NUM_CHANNELS];
        logic [31:0] stop_stamp  [NUM_CHANNELS];
        logic [31:0] rise_count [NUM_CHANNELS];
        bit          clear_due  [NUM_CHANNELS];
        t_out_item   awaited [$];
        int          failures;
        int          results_checked;
        int          saturated;
        int          negative_spans;

        function new();
            foreach (start_stamp[c]) begin
                start_stamp[c] = '0;
                stop_stamp[c]  = '0;
                rise_count[c] = '0;
                clear_due[c]  = 1'b0;
            end
            failures        = 0;
            results_checked = 0;
            saturated       = 0;
            negative_spans  = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
        endfunction

        // A read leaves the record in place; it is wiped at the channel's next edge or timeout.
        function void settle(int c);
            if (clear_due[c]) begin
                start_stamp[c] = '0;
                stop_stamp[c]  = '0;
                rise_count[c] = '0;
                clear_due[c]  = 1'b0;
            end
        endfunction

        function t_out_item measure(int c, bit known);
            t_out_item   res;
            logic [31:0] diff;
            logic [63:0] quot;
            res = '0;
            res.read_channel = 5'(c);
            if (known) begin
                diff = stop_stamp[c] - start_stamp[c];
                if (diff == 32'd0) diff = 32'd1;
                res.edge_tally = rise_count[c];
                if (diff[31]) begin
                    negative_spans++;
                end else begin
                    res.span_ticks = diff[30:0];
                    if (rise_count[c] != 32'd0) begin
                        // Round to nearest by adding half the span before dividing.
                        quot = ({32'd0, rise_count[c]} * 64'(SCALE_CENTIHZ)
                                + {34'd0, diff[30:1]}) / {33'd0, diff[30:0]};
                        if (quot > 64'hFFFF_FFFF) begin
                            res.freq_centihertz = '1;
                            saturated++;
                        end else begin
                            res.freq_centihertz = quot[31:0];
                        end
                    end
                end
            end
            return res;
        endfunction

        function void note_beat(t_in_item beat);
            int c;
            bit known;
            c     = int'(beat.channel);
            known = c < NUM_CHANNELS;
            case (beat.command)
                CMD_EDGE: if (known) begin
                    settle(c);
                    if (start_stamp[c] == 32'd0) start_stamp[c] = beat.tick;
                    stop_stamp[c] = beat.tick;
                    if (beat.level) rise_count[c] = rise_count[c] + 32'd1;
                end
                CMD_TIMEOUT: if (known) begin
                    settle(c);
                end
                CMD_READ: begin
                    awaited.push_back(measure(c, known));
                    if (known) clear_due[c] = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results_checked++;
            if (awaited.size() == 0) begin
                flag($sformatf("result with none expected: channel %0d tally %0d span %0d freq %0d",
                     got.read_channel, got.edge_tally, got.span_ticks, got.freq_centihertz));
                return;
            end
            want = awaited.pop_front();
            if (got.read_channel !== want.read_channel)
                flag($sformatf("read_channel: expected %0d, got %0d",
                     want.read_channel, got.read_channel));
            if (got.edge_tally !== want.edge_tally)
                flag($sformatf("edge_tally (channel %0d): expected %0d, got %0d",
                     want.read_channel, want.edge_tally, got.edge_tally));
            if (got.span_ticks !== want.span_ticks)
                flag($sformatf("span_ticks (channel %0d): expected %0d, got %0d",
                     want.read_channel, want.span_ticks, got.span_ticks));
            if (got.freq_centihertz !== want.freq_centihertz)
                flag($sformatf("freq_centihertz (channel %0d): expected %0d, got %0d",
                     want.read_channel, want.freq_centihertz, got.freq_centihertz));
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    bit         send_burst = 1'b0;
    bit         sink_burst = 1'b0;
    int         beats_sent = 0;
    int         idle_cycles = 0;
    freq_ledger ledger;

    mefc_in_if  in_bus ();
    mefc_out_if out_bus ();

    multichannel_edge_frequency_counter_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Valid stays high between back-to-back beats; it only drops when a gap is drawn.
    task automatic send_beat(input logic [1:0] cmd, input int ch, input logic lvl,
                             input logic [31:0] tick);
        t_in_item beat;
        int       gap;
        beat.command = cmd;
        beat.channel = 5'(ch);
        beat.level   = lvl;
        beat.tick    = tick;
        gap = send_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= beat;
        do @(posedge i_clk); while (!in_bus.ready);
        ledger.note_beat(beat);
        beats_sent++;
    endtask

    task automatic run_train();
        int          ch;
        int          edges;
        int          mode;
        logic        lvl;
        logic [31:0] tick;
        logic [31:0] step;
        ch    = $urandom_range(0, NUM_CHANNELS - 1);
        edges = $urandom_range(1, 12);
        mode  = $urandom_range(0, 9);
        tick  = $urandom;
        case ($urandom_range(0, 3))
            0:       step = $urandom_range(1, 3);
            1:       step = $urandom_range(1, 1000);
            2:       step = $urandom_range(1, 1000000);
            default: step = $urandom_range(1, 32'h1000_0000);
        endcase
        send_burst = ($urandom_range(0, 4) == 0);
        if (mode == 0) send_beat(CMD_TIMEOUT, ch, 1'($urandom_range(0, 1)), $urandom);
        for (int i = 0; i < edges; i++) begin
            lvl = (mode == 1) ? 1'($urandom_range(0, 1)) : 1'(i % 2 == 0);
            send_beat(CMD_EDGE, ch, lvl, (i == 0 && mode == 2) ? 32'd0 : tick);
            // Backward ticks give a negative span.
            tick = (mode == 3) ? tick - step : tick + step;
        end
        if (mode == 4) send_beat(CMD_TIMEOUT, ch, 1'($urandom_range(0, 1)), $urandom);
        send_beat(CMD_READ, ch, 1'($urandom_range(0, 1)), $urandom);
        if (mode == 5) send_beat(CMD_READ, ch, 1'($urandom_range(0, 1)), $urandom);
    endtask

    // Many rising edges within a span of one tick push the frequency near or into saturation.
    task automatic run_dense_train();
        int          ch;
        int          edges;
        logic [31:0] tick;
        ch    = $urandom_range(0, NUM_CHANNELS - 1);
        edges = $urandom_range(40, 56);
        tick  = $urandom;
        send_burst = 1'($urandom_range(0, 1));
        for (int i = 0; i < edges; i++)
            send_beat(CMD_EDGE, ch, 1'b1, (i == edges - 1) ? tick + $urandom_range(0, 1) : tick);
        send_beat(CMD_READ, ch, 1'b0, $urandom);
    endtask

    task automatic send_noise();
        send_burst = ($urandom_range(0, 2) == 0);
        send_beat(2'($urandom_range(0, 3)), $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                  $urandom);
    endtask

    initial begin : stimulus
        int pick;
        ledger = new();
        in_bus.valid  <= 1'b0;
        in_bus.data   <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(CMD_READ, 0, 1'b0, 32'd0);               // untouched channel
        send_beat(CMD_EDGE, 1, 1'b1, 32'd0);               // zero tick leaves the first tick open
        send_beat(CMD_EDGE, 1, 1'b1, 32'd1000);
        send_beat(CMD_READ, 1, 1'b0, 32'd0);
        send_beat(CMD_READ, 1, 1'b1, 32'hFFFF_FFFF);       // second read before any restart
        send_beat(CMD_TIMEOUT, 1, 1'b0, 32'd0);
        send_beat(CMD_READ, 1, 1'b0, 32'd0);
        send_beat(CMD_TIMEOUT, 2, 1'b1, 32'hFFFF_FFFF);    // nothing pending to clear
        send_beat(CMD_EDGE, 3, 1'b1, 32'hFFFF_FFFF);
        send_beat(CMD_EDGE, 3, 1'b0, 32'h7FFF_FFFE);       // widest positive span
        send_beat(CMD_READ, 3, 1'b0, 32'd0);
        send_beat(CMD_EDGE, 4, 1'b1, 32'd100);
        send_beat(CMD_EDGE, 4, 1'b1, 32'd50);
        send_beat(CMD_READ, 4, 1'b0, 32'd0);
        send_beat(CMD_EDGE, 31, 1'b0, 32'h8000_0000);
        send_beat(CMD_EDGE, 31, 1'b0, 32'h8000_0400);
        send_beat(CMD_READ, 31, 1'b1, 32'd0);              // edges seen but none rising
        send_beat(CMD_UNUSED, 5, 1'b1, 32'h1234_5678);
        send_beat(CMD_EDGE, 4, 1'b1, 32'd7);               // edge after a read restarts the record
        send_beat(CMD_EDGE, 4, 1'b1, 32'd8);
        send_beat(CMD_READ, 4, 1'b0, 32'd0);
        send_beat(CMD_EDGE, 3, 1'b1, 32'h7FFF_FFFF);
        send_beat(CMD_EDGE, 3, 1'b1, 32'hFFFF_FFFF);       // span just past the positive range
        send_beat(CMD_READ, 3, 1'b0, 32'd0);

        while (beats_sent < TARGET_BEATS) begin
            pick = $urandom_range(0, 29);
            if (pick < 24) run_train();
            else if (pick == 29) run_dense_train();
            else send_noise();
        end
        in_bus.valid <= 1'b0;

        while (ledger.awaited.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats; checked %0d reads, %0d saturated, %0d with negative span.",
                 beats_sent, ledger.results_checked, ledger.saturated, ledger.negative_spans);
        if (ledger.failures == 0) begin
            $display("multichannel_edge_frequency_counter_top_test: PASS");
        end else begin
            $display("%0d mismatches in total", ledger.failures);
            $display("multichannel_edge_frequency_counter_top_test: FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        int stall;
        out_bus.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_bus.valid && out_bus.ready));
            ledger.check_result(out_bus.data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("No beat moved for %0d cycles", idle_cycles);
            $display("multichannel_edge_frequency_counter_top_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
`default_nettype wire
